FILE: src/heading_kalman_fuser_top_defines.svh
// assertion macros used by the heading fuser top level rtl
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef HEADING_KALMAN_FUSER_TOP_DEFINES_SVH
`define HEADING_KALMAN_FUSER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HKF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define HKF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define HKF_ASSERT(lbl, prop, msg)
`define HKF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/hkf_pkg.sv
// types, constants and helper functions of the heading fuser
// no dependencies
`default_nettype none
package hkf_pkg;

    localparam int ANGLE_FRAC_BITS = 12;
    localparam int HEAD_W          = 15;
    localparam int VAR_W           = 16;
    localparam int MVAR_W          = 17;
    localparam int P_W             = 17;
    localparam int DEN_W           = 18;
    localparam int REM_W           = 34;
    localparam int DIV_STEPS       = 17;
    localparam int ANG_W           = 35;
    localparam int DIFF_W          = 34;
    localparam int ATAN_TABLE_SIZE = 24;
    localparam int ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;

    localparam logic signed [ANG_W-1:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 35'sd6746518852;
    localparam logic signed [ANG_W-1:0] Q30_ONE     = 35'sd1073741824;

    typedef enum logic [1:0] {
        CASE_NONE       = 2'd0,
        CASE_UNMEASURED = 2'd1,
        CASE_INIT       = 2'd2,
        CASE_FILTERED   = 2'd3
    } case_t;

    localparam logic REG_PROCESS_NOISE  = 1'b0;
    localparam logic REG_INIT_THRESHOLD = 1'b1;

    // payload between the front end and the rotate/divide pipeline
    typedef struct packed {
        case_t                     cs;
        logic signed [HEAD_W-1:0]  pass_heading;
        logic [VAR_W-1:0]          pass_variance;
        logic signed [ANG_W-1:0]   fx;
        logic signed [ANG_W-1:0]   fy;
        logic signed [ANG_W-1:0]   fz;
        logic                      fneg;
        logic signed [ANG_W-1:0]   mx;
        logic signed [ANG_W-1:0]   my;
        logic signed [ANG_W-1:0]   mz;
        logic                      mneg;
        logic [REM_W-1:0]          k_rem;
        logic [DIV_STEPS-1:0]      k_quo;
        logic [REM_W-1:0]          v_rem;
        logic [DIV_STEPS-1:0]      v_quo;
        logic [DEN_W-1:0]          den;
    } core_t;

    typedef struct packed {
        case_t                     cs;
        logic signed [HEAD_W-1:0]  heading;
        logic [VAR_W-1:0]          variance;
    } res_t;

    // arctan(2^-i) in q30 radians
    function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
        logic signed [ANG_W-1:0] a;
        case (idx)
            0:  a = 35'sd843314857;
            1:  a = 35'sd497837829;
            2:  a = 35'sd263043837;
            3:  a = 35'sd133525159;
            4:  a = 35'sd67021687;
            5:  a = 35'sd33543516;
            6:  a = 35'sd16775851;
            7:  a = 35'sd8388437;
            8:  a = 35'sd4194283;
            9:  a = 35'sd2097149;
            10: a = 35'sd1048576;
            11: a = 35'sd524288;
            12: a = 35'sd262144;
            13: a = 35'sd131072;
            14: a = 35'sd65536;
            15: a = 35'sd32768;
            16: a = 35'sd16384;
            17: a = 35'sd8192;
            18: a = 35'sd4096;
            19: a = 35'sd2048;
            20: a = 35'sd1024;
            21: a = 35'sd512;
            22: a = 35'sd256;
            23: a = 35'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

    // heading to q30, reduced once into [-pi, pi]
    function automatic logic signed [ANG_W-1:0] reduce_angle(
        input logic signed [HEAD_W-1:0] h
    );
        logic signed [ANG_W-1:0] raw;
        raw = ANG_W'(h);
        raw = raw <<< ANG_SHIFT;
        if (raw > Q30_PI) begin
            raw = raw - Q30_TWO_PI;
        end else if (raw < -Q30_PI) begin
            raw = raw + Q30_TWO_PI;
        end
        return raw;
    endfunction

endpackage
`default_nettype wire

FILE: src/hkf_prep.sv
// front end: case decision, angle reduction and fold, gain and variance dividends
// uses hkf_pkg
`default_nettype none
module hkf_prep (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic                          in_has_measurement,
    input  wire logic signed [14:0]            in_fused_heading,
    input  wire logic [15:0]                   in_fused_variance,
    input  wire logic signed [14:0]            in_measured_heading,
    input  wire logic signed [16:0]            in_measured_variance,
    input  wire logic [15:0]                   process_noise,
    input  wire logic [15:0]                   init_threshold,
    output logic                               out_valid,
    output hkf_pkg::core_t                     out_data
);
    import hkf_pkg::*;

    // stage a
    logic                     a_valid_reg;
    case_t                    a_cs_reg, a_cs_next;
    logic signed [HEAD_W-1:0] a_ph_reg, a_ph_next;
    logic [VAR_W-1:0]         a_pv_reg, a_pv_next;
    logic signed [ANG_W-1:0]  a_fz_reg, a_mz_reg;
    logic [P_W-1:0]           a_p_reg, a_p_next;
    logic [VAR_W-1:0]         a_r_reg;
    logic [DEN_W-1:0]         a_sum_reg, a_sum_next;

    always_comb begin
        if (!in_has_measurement) begin
            a_cs_next = CASE_NONE;
        end else if (in_measured_variance[MVAR_W-1]) begin
            a_cs_next = CASE_UNMEASURED;
        end else if (in_fused_variance > init_threshold) begin
            a_cs_next = CASE_INIT;
        end else begin
            a_cs_next = CASE_FILTERED;
        end
        if (a_cs_next == CASE_INIT) begin
            a_ph_next = in_measured_heading;
            a_pv_next = in_measured_variance[VAR_W-1:0];
        end else begin
            a_ph_next = in_fused_heading;
            a_pv_next = in_fused_variance;
        end
        a_p_next   = P_W'(in_fused_variance) + P_W'(process_noise);
        a_sum_next = DEN_W'(a_p_next) + DEN_W'(in_measured_variance[VAR_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
        if (en) begin
            a_cs_reg  <= a_cs_next;
            a_ph_reg  <= a_ph_next;
            a_pv_reg  <= a_pv_next;
            a_fz_reg  <= reduce_angle(in_fused_heading);
            a_mz_reg  <= reduce_angle(in_measured_heading);
            a_p_reg   <= a_p_next;
            a_r_reg   <= in_measured_variance[VAR_W-1:0];
            a_sum_reg <= a_sum_next;
        end
    end

    // stage b: fold into [-pi/2, pi/2], product p*r, rounded dividends
    logic                    b_valid_reg;
    core_t                   b_reg, b_next;
    logic [2*VAR_W:0]        pr;

    always_comb begin
        b_next               = '0;
        b_next.cs            = a_cs_reg;
        b_next.pass_heading  = a_ph_reg;
        b_next.pass_variance = a_pv_reg;
        b_next.fx            = Q30_ONE;
        b_next.mx            = Q30_ONE;
        b_next.fz            = a_fz_reg;
        b_next.mz            = a_mz_reg;
        if (a_fz_reg > Q30_HALF_PI) begin
            b_next.fz   = a_fz_reg - Q30_PI;
            b_next.fneg = 1'b1;
        end else if (a_fz_reg < -Q30_HALF_PI) begin
            b_next.fz   = a_fz_reg + Q30_PI;
            b_next.fneg = 1'b1;
        end
        if (a_mz_reg > Q30_HALF_PI) begin
            b_next.mz   = a_mz_reg - Q30_PI;
            b_next.mneg = 1'b1;
        end else if (a_mz_reg < -Q30_HALF_PI) begin
            b_next.mz   = a_mz_reg + Q30_PI;
            b_next.mneg = 1'b1;
        end
        pr           = a_p_reg * a_r_reg;
        b_next.k_rem = REM_W'({a_p_reg, 16'b0}) + REM_W'(a_sum_reg >> 1);
        b_next.v_rem = REM_W'(pr) + REM_W'(a_sum_reg >> 1);
        b_next.den   = a_sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
        if (en) begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule
`default_nettype wire

FILE: src/hkf_core.sv
// rotate cordic for both headings side by side with two restoring dividers
// uses hkf_pkg; at most one cordic step and one quotient bit per stage
`default_nettype none
module hkf_core #(
    parameter int CORDIC_STEPS = 14
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  hkf_pkg::core_t         in_data,
    output logic                   out_valid,
    output hkf_pkg::core_t         out_data
);
    import hkf_pkg::*;

    localparam int DEPTH = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;

    core_t pipe_reg  [DEPTH];
    logic  valid_reg [DEPTH];
    core_t stg       [DEPTH+1];
    logic  stg_valid [DEPTH+1];

    assign stg[0]       = in_data;
    assign stg_valid[0] = in_valid;

    for (genvar j = 0; j < DEPTH; j++) begin : g_stage
        // quotient bit settled by this stage, kept in range past the divider
        localparam int QBIT = (j < DIV_STEPS) ? (DIV_STEPS - 1 - j) : 0;
        core_t                   pipe_next;
        logic [REM_W:0]          k_shift, v_shift;

        always_comb begin
            pipe_next = stg[j];
            k_shift   = '0;
            v_shift   = '0;
            if (j < CORDIC_STEPS) begin
                if (stg[j].fz >= 0) begin
                    pipe_next.fx = stg[j].fx - (stg[j].fy >>> j);
                    pipe_next.fy = stg[j].fy + (stg[j].fx >>> j);
                    pipe_next.fz = stg[j].fz - atan_q30(j);
                end else begin
                    pipe_next.fx = stg[j].fx + (stg[j].fy >>> j);
                    pipe_next.fy = stg[j].fy - (stg[j].fx >>> j);
                    pipe_next.fz = stg[j].fz + atan_q30(j);
                end
                if (stg[j].mz >= 0) begin
                    pipe_next.mx = stg[j].mx - (stg[j].my >>> j);
                    pipe_next.my = stg[j].my + (stg[j].mx >>> j);
                    pipe_next.mz = stg[j].mz - atan_q30(j);
                end else begin
                    pipe_next.mx = stg[j].mx + (stg[j].my >>> j);
                    pipe_next.my = stg[j].my - (stg[j].mx >>> j);
                    pipe_next.mz = stg[j].mz + atan_q30(j);
                end
            end
            if (j < DIV_STEPS) begin
                k_shift = (REM_W+1)'(stg[j].den) << QBIT;
                v_shift = k_shift;
                if ({1'b0, stg[j].k_rem} >= k_shift) begin
                    pipe_next.k_rem = stg[j].k_rem - REM_W'(k_shift);
                    pipe_next.k_quo[QBIT] = 1'b1;
                end
                if ({1'b0, stg[j].v_rem} >= v_shift) begin
                    pipe_next.v_rem = stg[j].v_rem - REM_W'(v_shift);
                    pipe_next.v_quo[QBIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= stg_valid[j];
            end
            if (en) begin
                pipe_reg[j] <= pipe_next;
            end
        end

        assign stg[j+1]       = pipe_reg[j];
        assign stg_valid[j+1] = valid_reg[j];
    end

    assign out_valid = stg_valid[DEPTH];
    assign out_data  = stg[DEPTH];

endmodule
`default_nettype wire

FILE: src/hkf_vec.sv
// blend by the gain, vectoring cordic atan2, rounding to the output heading
// uses hkf_pkg
`default_nettype none
module hkf_vec #(
    parameter int CORDIC_STEPS = 14
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  hkf_pkg::core_t         in_data,
    output logic                   out_valid,
    output hkf_pkg::res_t          out_data
);
    import hkf_pkg::*;

    typedef struct packed {
        case_t                    cs;
        logic signed [HEAD_W-1:0] ph;
        logic [VAR_W-1:0]         pv;
        logic [VAR_W-1:0]         nv;
    } side_t;

    typedef struct packed {
        side_t                    sd;
        logic signed [ANG_W-1:0]  x;
        logic signed [ANG_W-1:0]  y;
        logic signed [ANG_W-1:0]  z;
        logic                     zero;
    } vec_t;

    localparam logic signed [ANG_W-1:0] ROUND_HALF = ANG_W'(1) <<< (ANG_SHIFT - 1);
    localparam logic signed [ANG_W-1:0] HEAD_MAX_Q = ANG_W'((2 ** (HEAD_W - 1)) - 1);
    localparam logic signed [ANG_W-1:0] HEAD_MIN_Q = -ANG_W'(2 ** (HEAD_W - 1));

    // v0: unfold signs, gain and variance out of the dividers
    logic                     v0_valid_reg;
    side_t                    v0_sd_reg, v0_sd_next;
    logic signed [ANG_W-1:0]  v0_sf_reg, v0_cf_reg, v0_sf_next, v0_cf_next;
    logic signed [DIFF_W-1:0] v0_ds_reg, v0_dc_reg;
    logic [DIV_STEPS-1:0]     v0_k_reg, v0_k_next;
    logic signed [ANG_W-1:0]  sm, cm;

    always_comb begin
        v0_sf_next = in_data.fneg ? -in_data.fy : in_data.fy;
        v0_cf_next = in_data.fneg ? -in_data.fx : in_data.fx;
        sm         = in_data.mneg ? -in_data.my : in_data.my;
        cm         = in_data.mneg ? -in_data.mx : in_data.mx;
        v0_sd_next.cs = in_data.cs;
        v0_sd_next.ph = in_data.pass_heading;
        v0_sd_next.pv = in_data.pass_variance;
        if (in_data.den == '0) begin
            v0_k_next     = '0;
            v0_sd_next.nv = '0;
        end else begin
            v0_k_next     = in_data.k_quo;
            v0_sd_next.nv = in_data.v_quo[DIV_STEPS-1] ? '1 : in_data.v_quo[VAR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_valid_reg <= 1'b0;
        end else if (en) begin
            v0_valid_reg <= in_valid;
        end
        if (en) begin
            v0_sd_reg <= v0_sd_next;
            v0_sf_reg <= v0_sf_next;
            v0_cf_reg <= v0_cf_next;
            v0_ds_reg <= DIFF_W'(sm - v0_sf_next);
            v0_dc_reg <= DIFF_W'(cm - v0_cf_next);
            v0_k_reg  <= v0_k_next;
        end
    end

    // v1: gain times difference
    localparam int PROD_W = DIFF_W + DIV_STEPS + 1;
    logic                     v1_valid_reg;
    side_t                    v1_sd_reg;
    logic signed [ANG_W-1:0]  v1_sf_reg, v1_cf_reg;
    logic signed [PROD_W-1:0] v1_ps_reg, v1_pc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_valid_reg <= 1'b0;
        end else if (en) begin
            v1_valid_reg <= v0_valid_reg;
        end
        if (en) begin
            v1_sd_reg <= v0_sd_reg;
            v1_sf_reg <= v0_sf_reg;
            v1_cf_reg <= v0_cf_reg;
            v1_ps_reg <= $signed({1'b0, v0_k_reg}) * v0_ds_reg;
            v1_pc_reg <= $signed({1'b0, v0_k_reg}) * v0_dc_reg;
        end
    end

    // v2: blended sine and cosine
    logic                     v2_valid_reg;
    side_t                    v2_sd_reg;
    logic signed [ANG_W-1:0]  v2_sb_reg, v2_cb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_valid_reg <= 1'b0;
        end else if (en) begin
            v2_valid_reg <= v1_valid_reg;
        end
        if (en) begin
            v2_sd_reg <= v1_sd_reg;
            v2_sb_reg <= v1_sf_reg + ANG_W'(v1_ps_reg >>> 16);
            v2_cb_reg <= v1_cf_reg + ANG_W'(v1_pc_reg >>> 16);
        end
    end

    // v3: move the vector into the right half plane
    logic  v3_valid_reg;
    vec_t  v3_reg, v3_next;

    always_comb begin
        v3_next.sd   = v2_sd_reg;
        v3_next.zero = (v2_sb_reg == '0) && (v2_cb_reg == '0);
        v3_next.x    = v2_cb_reg;
        v3_next.y    = v2_sb_reg;
        v3_next.z    = '0;
        if (v2_cb_reg < 0) begin
            v3_next.x = -v2_cb_reg;
            v3_next.y = -v2_sb_reg;
            v3_next.z = (v2_sb_reg >= 0) ? Q30_PI : -Q30_PI;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_valid_reg <= 1'b0;
        end else if (en) begin
            v3_valid_reg <= v2_valid_reg;
        end
        if (en) begin
            v3_reg <= v3_next;
        end
    end

    // vectoring steps
    vec_t vpipe_reg  [CORDIC_STEPS];
    logic vvalid_reg [CORDIC_STEPS];
    vec_t vstg       [CORDIC_STEPS+1];
    logic vstg_valid [CORDIC_STEPS+1];

    assign vstg[0]       = v3_reg;
    assign vstg_valid[0] = v3_valid_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vstep
        vec_t vpipe_next;

        always_comb begin
            vpipe_next = vstg[i];
            if (vstg[i].y >= 0) begin
                vpipe_next.x = vstg[i].x + (vstg[i].y >>> i);
                vpipe_next.y = vstg[i].y - (vstg[i].x >>> i);
                vpipe_next.z = vstg[i].z + atan_q30(i);
            end else begin
                vpipe_next.x = vstg[i].x - (vstg[i].y >>> i);
                vpipe_next.y = vstg[i].y + (vstg[i].x >>> i);
                vpipe_next.z = vstg[i].z - atan_q30(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vvalid_reg[i] <= 1'b0;
            end else if (en) begin
                vvalid_reg[i] <= vstg_valid[i];
            end
            if (en) begin
                vpipe_reg[i] <= vpipe_next;
            end
        end

        assign vstg[i+1]       = vpipe_reg[i];
        assign vstg_valid[i+1] = vvalid_reg[i];
    end

    // rounding, saturation and case select
    vec_t                    last;
    logic signed [ANG_W-1:0] rounded;
    logic signed [HEAD_W-1:0] heading;

    always_comb begin
        last    = vstg[CORDIC_STEPS];
        rounded = (last.z + ROUND_HALF) >>> ANG_SHIFT;
        if (last.zero) begin
            heading = '0;
        end else if (rounded > HEAD_MAX_Q) begin
            heading = HEAD_MAX_Q[HEAD_W-1:0];
        end else if (rounded < HEAD_MIN_Q) begin
            heading = HEAD_MIN_Q[HEAD_W-1:0];
        end else begin
            heading = rounded[HEAD_W-1:0];
        end
        out_data.cs = last.sd.cs;
        if (last.sd.cs == CASE_FILTERED) begin
            out_data.heading  = heading;
            out_data.variance = last.sd.nv;
        end else begin
            out_data.heading  = last.sd.ph;
            out_data.variance = last.sd.pv;
        end
    end

    assign out_valid = vstg_valid[CORDIC_STEPS];

endmodule
`default_nettype wire

FILE: src/heading_kalman_fuser_top.sv
// top level of the heading fuser: stream ports, config registers, output register
// uses hkf_pkg, hkf_prep, hkf_core, hkf_vec and heading_kalman_fuser_top_defines.svh
//
//  channel   direction  fields (low bit first)
//  s_*       in         tuser: has_measurement; tdata: fused_heading, fused_variance,
//                       measured_heading, measured_variance
//  m_*       out        tuser: update_case; tdata: new_heading, new_variance
//  cfg_*     in         index 0 process_noise, index 1 init_threshold
//
// one transaction per cycle while the output is not stalled; the pipeline depth grows with
// S = min(CORDIC_ITERATIONS, 24), set by the 17-bit divider and the two cordic chains
// the whole pipeline moves as one: it halts only while the output register is full
// and m_tready is low, so a stall neither drops nor repeats a transaction
// synchronous active-low reset clears the valid bits and loads the config register defaults
`default_nettype none
`include "heading_kalman_fuser_top_defines.svh"
module heading_kalman_fuser_top #(
    parameter int CORDIC_ITERATIONS = 14
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // fused_heading, fused_variance,
                                        // measured_heading, measured_variance
    input  wire logic [0:0]  s_tuser,   // has_measurement
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // new_heading, new_variance
    output logic [1:0]       m_tuser,   // update_case
    // config writes
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import hkf_pkg::*;

    localparam int STEPS = (CORDIC_ITERATIONS > ATAN_TABLE_SIZE) ?
                           ATAN_TABLE_SIZE : CORDIC_ITERATIONS;

    // config registers
    logic [15:0] process_noise_reg, init_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            process_noise_reg  <= 16'd80;
            init_threshold_reg <= 16'd25600;
        end else if (cfg_wr_en) begin
            case (cfg_index[0])
                REG_PROCESS_NOISE:  process_noise_reg  <= cfg_wdata;
                REG_INIT_THRESHOLD: init_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // the pipeline advances whenever the output slot is free or being drained
    logic pipe_en;
    logic out_valid_reg;
    res_t out_reg;

    assign pipe_en  = !out_valid_reg || m_tready;
    assign s_tready = pipe_en;

    // front end
    logic  prep_valid;
    core_t prep_data;

    hkf_prep u_prep (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .en                   (pipe_en),
        .in_valid             (s_tvalid),
        .in_has_measurement   (s_tuser[0]),
        .in_fused_heading     ($signed(s_tdata[14:0])),
        .in_fused_variance    (s_tdata[30:15]),
        .in_measured_heading  ($signed(s_tdata[45:31])),
        .in_measured_variance ($signed(s_tdata[62:46])),
        .process_noise        (process_noise_reg),
        .init_threshold       (init_threshold_reg),
        .out_valid            (prep_valid),
        .out_data             (prep_data)
    );

    // sine/cosine of both headings, gain and updated variance
    logic  core_out_valid;
    core_t core_out;

    hkf_core #(
        .CORDIC_STEPS (STEPS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (prep_valid),
        .in_data   (prep_data),
        .out_valid (core_out_valid),
        .out_data  (core_out)
    );

    // blend and atan2
    logic vec_out_valid;
    res_t vec_out;

    hkf_vec #(
        .CORDIC_STEPS (STEPS)
    ) u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (core_out_valid),
        .in_data   (core_out),
        .out_valid (vec_out_valid),
        .out_data  (vec_out)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= vec_out_valid;
        end
        if (pipe_en) begin
            out_reg <= vec_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.variance, out_reg.heading};
    assign m_tuser  = out_reg.cs;

    `HKF_ASSERT_ALWAYS(a_reset_empties_output, !aresetn |=> !m_tvalid, "output valid after reset")
    `HKF_ASSERT(a_cfg_only_on_write, !cfg_wr_en |=> $stable(process_noise_reg) && $stable(init_threshold_reg), "config changed without write")
    `HKF_ASSERT(a_stall_freezes_pipe, !pipe_en |=> $stable(core_out_valid) && $stable(vec_out_valid), "pipeline moved while stalled")

endmodule
`default_nettype wire

FILE: bench/heading_kalman_fuser_top_tb.sv
// self-checking bench for heading_kalman_fuser_top: directed and random heading updates
// depends on hkf_pkg and the heading_kalman_fuser_top rtl; predicts every result in place
`timescale 1ns / 1ps
module heading_kalman_fuser_top_tb;
    import hkf_pkg::*;

    localparam int STEPS = 14;
    localparam int LATENCY = 2 + ((STEPS > 17) ? STEPS : 17) + 4 + STEPS + 1;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam int CYCLE_LIMIT = 400000;

    // expected result of one update
    typedef struct {
        logic signed [14:0] heading;
        logic [15:0]        variance;
        case_t              cs;
    } upd_t;

    // arctan(2^-i) table in q30
    localparam longint ARCTAN [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128};

    // arithmetic shift right with floor
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // rotation cordic: sine and cosine of a heading, gain kept
    function automatic void rotate_heading(input longint h, output longint s,
                                           output longint c);
        longint z, x, y, xs, ys;
        bit flip;
        z = h * (64'sd1 << (30 - 12));
        x = 64'sd1 << 30;
        y = 0;
        flip = 0;
        while (z > PI_Q30) z -= TWO_PI_Q30;
        while (z < -PI_Q30) z += TWO_PI_Q30;
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30; flip = 1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30; flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = shr_floor(x, i); ys = shr_floor(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= ARCTAN[i];
            end else begin
                x += ys; y -= xs; z += ARCTAN[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // vectoring cordic: angle of (x, y), zero for the null vector
    function automatic longint vector_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q30 : -PI_Q30;
            x = -x; y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = shr_floor(x, i); ys = shr_floor(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += ARCTAN[i];
            end else begin
                x -= ys; y += xs; z -= ARCTAN[i];
            end
        end
        return z;
    endfunction

    // one kalman heading update
    function automatic upd_t fuse_heading(bit has, logic signed [14:0] fh, logic [15:0] fv,
                                          logic signed [14:0] mh, logic signed [16:0] mv,
                                          logic [15:0] q, logic [15:0] thr);
        upd_t u;
        longint p, r, sum, k, sf, cf, sm, cm, sb, cb, z, nh, nv;
        u.heading = fh; u.variance = fv;
        if (!has) begin
            u.cs = CASE_NONE;
        end else if (mv < 0) begin
            u.cs = CASE_UNMEASURED;
        end else if (fv > thr) begin
            u.heading = mh; u.variance = mv[15:0]; u.cs = CASE_INIT;
        end else begin
            p = longint'(fv) + longint'(q);
            r = longint'(mv);
            sum = p + r;
            k = 0; nv = 0;
            if (sum != 0) begin
                k = ((p << 16) + sum / 2) / sum;
                nv = (p * r + sum / 2) / sum;
            end
            if (nv > 65535) nv = 65535;
            rotate_heading(longint'(fh), sf, cf);
            rotate_heading(longint'(mh), sm, cm);
            sb = sf + shr_floor(k * (sm - sf), 16);
            cb = cf + shr_floor(k * (cm - cf), 16);
            z = vector_angle(sb, cb);
            nh = shr_floor(z + (64'sd1 << 17), 18);
            if (nh > 16383) nh = 16383;
            if (nh < -16384) nh = -16384;
            u.heading = nh[14:0]; u.variance = nv[15:0]; u.cs = CASE_FILTERED;
        end
        return u;
    endfunction

    // pending updates in order, checked against the result stream
    class update_scoreboard;
        upd_t pending[$];
        int errors;
        int checked;
        function void note_input(upd_t u);
            pending.push_back(u);
        endfunction
        function void check_result(logic [31:0] d, logic [1:0] cu);
            upd_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result tdata=%h tuser=%0d", $realtime, d, cu);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (d[14:0] !== e.heading) begin
                $display("%0t heading expected %0d actual %0d", $realtime, e.heading,
                         $signed(d[14:0]));
                errors++;
            end
            if (d[30:15] !== e.variance) begin
                $display("%0t variance expected %0d actual %0d", $realtime, e.variance,
                         d[30:15]);
                errors++;
            end
            if (cu !== e.cs) begin
                $display("%0t case expected %0d actual %0d", $realtime, e.cs, cu);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [31:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_wr_en = 0;
    logic [0:0] cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // config copy held by the predictor
    logic [15:0] noise_reg = 16'd80;
    logic [15:0] thresh_reg = 16'd25600;

    update_scoreboard sb = new();
    bit idle_enable = 1;     // random gaps allowed on both sides
    bit long_hold = 0;       // receiver holds off for a long stretch
    int cycles = 0;
    int n_sent = 0;

    always #2 aclk = ~aclk;

    heading_kalman_fuser_top #(.CORDIC_ITERATIONS(STEPS)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // cycle guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check every accepted transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // receiver ready with random bursts of stall
    initial begin : receiver
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 0;
                repeat (200) @(posedge aclk);
                long_hold = 0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 4);
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    // register write, only while the block is idle
    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        if (idx == REG_PROCESS_NOISE) noise_reg = val;
        else thresh_reg = val;
        @(posedge aclk);
    endtask

    // wait for every pending result, then let the pipeline drain
    task automatic drain_results();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // offer one transaction and hold it until accepted
    task automatic send_update(bit has, logic signed [14:0] fh, logic [15:0] fv,
                               logic signed [14:0] mh, logic signed [16:0] mv);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= has;
        s_tdata <= {1'b0, mv, mh, fv, fh};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(fuse_heading(has, fh, fv, mh, mv, noise_reg, thresh_reg));
        n_sent++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 0;
        @(posedge aclk);
    endtask

    // random update, mostly measured ones with a spread of variances
    task automatic send_random();
        int kind;
        logic signed [14:0] fh, mh;
        logic [15:0] fv;
        logic signed [16:0] mv;
        kind = $urandom_range(0, 9);
        fh = (kind == 9) ? 15'($urandom) : 15'($signed($urandom_range(0, 25736)) - 12868);
        mh = (kind == 8) ? 15'($urandom) : 15'($signed($urandom_range(0, 25736)) - 12868);
        fv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        mv = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 65535))
                                          : 17'($urandom_range(0, 2000));
        if (kind == 0) send_update(0, fh, fv, mh, 17'($urandom));
        else if (kind == 1) send_update(1, fh, fv, mh, -17'sd1 - 17'($urandom_range(0, 65535)));
        else send_update(1, fh, fv, mh, mv);
    endtask

    task automatic random_phase(int count);
        repeat (count) send_random();
        stop_sending();
        drain_results();
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: every case, field extremes, null blend
        send_update(0, 15'sd12868, 16'hFFFF, -15'sd12868, 17'h1FFFF);
        send_update(1, -15'sd12868, 16'd0, 15'sd12868, -17'sd1);
        send_update(1, 15'sd100, 16'd100, 15'sd200, -17'sd65536);
        send_update(1, 15'sd300, 16'd25601, -15'sd400, 17'sd65535);
        send_update(1, 15'sd0, 16'd65535, 15'sd12868, 17'sd0);
        send_update(1, 15'sd1000, 16'd25600, 15'sd2000, 17'sd256);
        send_update(1, 15'sd12868, 16'd0, -15'sd12868, 17'sd0);
        send_update(1, 15'sd6434, 16'd500, -15'sd6434, 17'sd420);
        send_update(1, -15'sd16384, 16'd10, 15'sd16383, 17'sd10);
        send_update(1, 15'sd16383, 16'd0, -15'sd16384, 17'sd65535);
        send_update(1, 15'sd0, 16'd0, 15'sd12868, 17'sd80);
        send_update(1, 15'sd5000, 16'd25600, 15'sd5000, 17'sd65535);
        send_update(1, -15'sd3000, 16'd1, 15'sd3000, 17'sd1);
        stop_sending();
        drain_results();

        // zero process noise and zero threshold: zero total variance case
        write_reg(REG_PROCESS_NOISE, 16'd0);
        write_reg(REG_INIT_THRESHOLD, 16'd0);
        send_update(1, 15'sd7000, 16'd0, -15'sd2000, 17'sd0);
        send_update(1, -15'sd12000, 16'd0, 15'sd9000, 17'sd0);
        send_update(1, 15'sd7000, 16'd1, -15'sd2000, 17'sd5);
        random_phase(150);

        // maximum settings; long receiver hold while the sender keeps offering
        write_reg(REG_PROCESS_NOISE, 16'hFFFF);
        write_reg(REG_INIT_THRESHOLD, 16'hFFFF);
        long_hold = 1;
        random_phase(250);

        // middle settings
        write_reg(REG_PROCESS_NOISE, 16'(($urandom_range(0, 4000))));
        write_reg(REG_INIT_THRESHOLD, 16'($urandom));
        random_phase(250);

        // back to the defaults, no idling at the end
        write_reg(REG_PROCESS_NOISE, 16'd80);
        write_reg(REG_INIT_THRESHOLD, 16'd25600);
        random_phase(150);
        idle_enable = 0;
        random_phase(200);

        $display("sent %0d heading updates over five register settings, %0d results checked",
                 n_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
